FILE: sv/pasf_pkg.sv
// Shared types and constants for the PWM audio sample FIFO.
package pasf_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int VOLUME_W   = 7;
  localparam int COUNT_W    = 16;
  localparam int DUTY_BITS  = 10;
  localparam int DUTY_SHIFT = SAMPLE_W - DUTY_BITS;

  // Defaults for top-level parameters
  localparam int RING_DEPTH_DEF = 8192;

  // Volume register
  localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(80);
  localparam logic [VOLUME_W-1:0] VOLUME_FULL  = VOLUME_W'(100);

  // Divide by 100 as multiply by ceil(2^29/100) and shift; exact for |x| < 2^22
  localparam int                RECIP_SHIFT = 29;
  localparam int                RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = RECIP_W'(5368710);

  // Offset that moves a signed sample to unsigned mid-scale
  localparam logic [SAMPLE_W:0] SAMPLE_OFFSET = (SAMPLE_W+1)'(32768);

  localparam logic [DUTY_BITS-1:0] DUTY_MID = DUTY_BITS'(1 << (DUTY_BITS - 1));
  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       batch_end;
  } req_t;

  typedef struct packed {
    logic                 is_duty;
    logic                 accepted;
    logic [COUNT_W-1:0]   written_count;
    logic [DUTY_BITS-1:0] left_duty;
    logic [DUTY_BITS-1:0] right_duty;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_MID,
    S_RD_L,
    S_RD_R,
    S_DR,
    S_P1,
    S_P2
  } state_t;

endpackage

FILE: sv/pasf_ring.sv
// Sample ring storage: one write port, one registered read port.
module pasf_ring import pasf_pkg::*; #(
  parameter int DEPTH = RING_DEPTH_DEF,
  parameter int AW    = $clog2(RING_DEPTH_DEF)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pasf_duty.sv
// Sample to PWM duty conversion: volume scale, divide by 100, offset, shift.
module pasf_duty import pasf_pkg::*; (
  input  logic                       clk,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOLUME_W-1:0]        volume,
  output logic [DUTY_BITS-1:0]       duty
);

  localparam int PROD_W = SAMPLE_W + VOLUME_W + 1;
  localparam int MAG_W  = PROD_W - 1;
  localparam int QW     = MAG_W + RECIP_W;

  logic signed [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]           mag;
  logic [QW-1:0]              qprod;
  logic                       neg;
  logic [SAMPLE_W-1:0]        quot;
  logic signed [SAMPLE_W:0]   scaled;
  logic [SAMPLE_W:0]          biased;

  // stage 1: sample times volume
  always_ff @(posedge clk) begin
    prod <= PROD_W'(sample) * $signed({1'b0, volume});
  end

  // stage 2: magnitude divided by 100 via reciprocal, truncating toward zero
  always_comb begin
    mag   = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
    qprod = QW'(mag) * QW'(RECIP_MUL);
  end

  always_ff @(posedge clk) begin
    neg  <= prod[PROD_W-1];
    quot <= qprod[RECIP_SHIFT +: SAMPLE_W];
  end

  // restore sign, offset to unsigned, keep the top duty bits
  // (result always lies within 0..65535, so the shifted value never exceeds the top code)
  always_comb begin
    scaled = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    biased = $unsigned(scaled) + SAMPLE_OFFSET;
    duty   = biased[SAMPLE_W-1:DUTY_SHIFT];
  end

endmodule

FILE: sv/pwm_audio_sample_fifo.sv
// PWM audio sample ring: write/tick sequencer around the ring memory and duty unit.
// Write request: accepted at start, written in S_WR, result strobed on done; a new
// request is taken only back in S_IDLE. Tick: mid-scale duty before playing, else
// two ring reads on the single read port, then the two-stage duty unit.
// Reset clears pointers, playing flag, batch state and sets volume to 80; ring
// contents are not cleared. Results cannot be stalled; each shows for one cycle.
module pwm_audio_sample_fifo import pasf_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                request,
  output logic                done,
  output res_t                result,
  input  logic                volume_write,
  input  logic [VOLUME_W-1:0] volume_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  state_t               state, state_next;
  req_t                 req, req_next;
  logic [PTR_W-1:0]     wp, wp_next, rp, rp_next;
  logic                 playing, playing_next;
  logic                 stopped, stopped_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 hit_l, hit_l_next, hit_r, hit_r_next;
  logic [DUTY_BITS-1:0] left, left_next;
  logic [VOLUME_W-1:0]  volume;
  res_t                 result_next;
  logic                 done_next;

  logic                       ram_we;
  logic [PTR_W-1:0]           ram_raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] duty_in;
  logic [DUTY_BITS-1:0]       duty_out;

  pasf_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (req.sample_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pasf_duty u_duty (
    .clk    (clk),
    .sample (duty_in),
    .volume (volume),
    .duty   (duty_out)
  );

  assign busy = (state != S_IDLE);

  // volume register, clamped to full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (volume_write) begin
      volume <= (volume_data > VOLUME_FULL) ? VOLUME_FULL : volume_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      rp      <= '0;
      playing <= 1'b0;
      stopped <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      rp      <= rp_next;
      playing <= playing_next;
      stopped <= stopped_next;
      count   <= count_next;
      done    <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req    <= req_next;
    hit_l  <= hit_l_next;
    hit_r  <= hit_r_next;
    left   <= left_next;
    result <= result_next;
  end

  // sequencer
  always_comb begin
    logic               wok;
    logic               wstop;
    logic [COUNT_W-1:0] wcnt;

    state_next   = state;
    req_next     = req;
    wp_next      = wp;
    rp_next      = rp;
    playing_next = playing;
    stopped_next = stopped;
    count_next   = count;
    hit_l_next   = hit_l;
    hit_r_next   = hit_r;
    left_next    = left;
    result_next  = result;
    done_next    = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = rp;
    duty_in      = '0;
    wok          = 1'b0;
    wstop        = stopped;
    wcnt         = count;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = request;
          if (request.operation == OP_TICK) begin
            state_next = playing ? S_RD_L : S_MID;
          end else begin
            state_next = S_WR;
          end
        end
      end

      // push one sample unless the ring is full or the batch already hit a full ring
      S_WR: begin
        playing_next = 1'b1;
        if (!stopped) begin
          if (ring_next(wp) == rp) begin
            wstop = 1'b1;
          end else begin
            ram_we  = 1'b1;
            wp_next = ring_next(wp);
            wok     = 1'b1;
            if (count != COUNT_MAX) begin
              wcnt = count + 1'b1;
            end
          end
        end
        result_next = '{is_duty: 1'b0, accepted: wok, written_count: wcnt,
                        left_duty: '0, right_duty: '0};
        done_next   = 1'b1;
        if (req.batch_end) begin
          count_next   = '0;
          stopped_next = 1'b0;
        end else begin
          count_next   = wcnt;
          stopped_next = wstop;
        end
        state_next = S_IDLE;
      end

      // not playing yet: silence on both channels
      S_MID: begin
        result_next = '{is_duty: 1'b1, accepted: 1'b0, written_count: '0,
                        left_duty: DUTY_MID, right_duty: DUTY_MID};
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      // read left sample
      S_RD_L: begin
        ram_raddr  = rp;
        hit_l_next = (rp != wp);
        if (rp != wp) begin
          rp_next = ring_next(rp);
        end
        state_next = S_RD_R;
      end

      // read right sample, left data into duty unit
      S_RD_R: begin
        ram_raddr  = rp;
        hit_r_next = (rp != wp);
        if (rp != wp) begin
          rp_next = ring_next(rp);
        end
        duty_in    = hit_l ? $signed(ram_rdata) : '0;
        state_next = S_DR;
      end

      // right data into duty unit
      S_DR: begin
        duty_in    = hit_r ? $signed(ram_rdata) : '0;
        state_next = S_P1;
      end

      // left duty ready
      S_P1: begin
        left_next  = duty_out;
        state_next = S_P2;
      end

      // right duty ready, issue result
      S_P2: begin
        result_next = '{is_duty: 1'b1, accepted: 1'b0, written_count: '0,
                        left_duty: left, right_duty: duty_out};
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
